>>> design/rc4_stream_cipher_assert.svh
// Assertion macros for the RC4 cipher block (clocked by clk, reset by arst_n).
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication.
`define RC4_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rc4 check failed");

// Next-cycle implication.
`define RC4_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rc4 check failed");

`endif

>>> design/rc4_pkg.sv
// Shared types and constants for the RC4 cipher block.
package rc4_pkg;

	localparam int KEY_MAX_DEF = 256;
	localparam int SBOX_DEPTH  = 256;

	// Request kinds
	localparam logic KIND_KEY  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KS_INIT,
		ST_KS_RD_I,
		ST_KS_RD_J,
		ST_KS_WR_I,
		ST_KS_WR_J,
		ST_DT_RD_I,
		ST_DT_RD_J,
		ST_DT_WR_I,
		ST_DT_WR_J,
		ST_DT_DONE
	} state_t;

	// Permutation memory port request
	typedef struct packed {
		logic       we;
		logic [7:0] waddr;
		logic [7:0] wdata;
		logic [7:0] raddr;
	} s_req_t;

	// Sequencer status
	typedef struct packed {
		logic idle;
		logic sched;
	} stat_t;

endpackage

>>> design/rc4_in_if.sv
// Request channel: key or data byte.
interface rc4_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] value_in;
	logic       last_key;

	modport source (output valid, output kind, output value_in, output last_key, input ready);
	modport sink   (input valid, input kind, input value_in, input last_key, output ready);
endinterface

>>> design/rc4_out_if.sv
// Result channel: processed byte and keyed status.
interface rc4_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;
	logic       not_keyed;

	modport source (output valid, output data_out, output not_keyed, input ready);
	modport sink   (input valid, input data_out, input not_keyed, output ready);
endinterface

>>> design/rc4_ram.sv
// Single-write, single-read RAM with registered read data.
module rc4_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> design/rc4_ctrl.sv
// Sequencer for key load, key schedule and keystream generation with one shared adder.
module rc4_ctrl #(
	parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF,
	localparam int KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	rc4_in_if.sink              item,
	rc4_out_if.source           result,
	output rc4_pkg::s_req_t     s_req,
	input  logic [7:0]          s_rdata,
	output logic                k_we,
	output logic [KEY_AW-1:0]   k_waddr,
	output logic [7:0]          k_wdata,
	output logic [KEY_AW-1:0]   k_raddr,
	input  logic [7:0]          k_rdata,
	output rc4_pkg::stat_t      stat
);
	import rc4_pkg::*;

	localparam int KEY_CW = $clog2(KEY_MAX + 1);

	state_t              state_q, state_d;
	logic [7:0]          n_q, i_q, j_q, si_q, sj_q, t_q, ks_q, val_q;
	logic                nk_q, keyed_q;
	logic [KEY_AW-1:0]   k_idx_q;
	logic [KEY_CW-1:0]   key_count_q, key_len, k_inc;
	logic                out_vld_q, out_nk_q;
	logic [7:0]          out_data_q;
	logic [7:0]          add_a, add_b, add_c, sum;
	logic [7:0]          ks_fwd;
	logic                acc, out_free, key_room;

	assign acc      = item.valid && item.ready;
	assign out_free = !out_vld_q || result.ready;
	assign key_room = key_count_q < KEY_CW'(KEY_MAX);
	assign key_len  = (key_count_q == '0) ? KEY_CW'(1) : key_count_q;
	assign k_inc    = KEY_CW'(k_idx_q) + KEY_CW'(1);

	// Shared adder
	assign sum = add_a + add_b + add_c;

	// Keystream byte with forwarding of the two swapped entries
	always_comb begin
		if (t_q == i_q) begin
			ks_fwd = sj_q;
		end else if (t_q == j_q) begin
			ks_fwd = si_q;
		end else begin
			ks_fwd = s_rdata;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (item.kind == KIND_KEY) begin
						if (item.last_key) begin
							state_d = ST_KS_INIT;
						end
					end else if (keyed_q) begin
						state_d = ST_DT_RD_I;
					end else begin
						state_d = ST_DT_DONE;
					end
				end
			end
			ST_KS_INIT: begin
				if (n_q == 8'hFF) begin
					state_d = ST_KS_RD_I;
				end
			end
			ST_KS_RD_I: state_d = ST_KS_RD_J;
			ST_KS_RD_J: state_d = ST_KS_WR_I;
			ST_KS_WR_I: state_d = ST_KS_WR_J;
			ST_KS_WR_J: begin
				state_d = (n_q == 8'hFF) ? ST_IDLE : ST_KS_RD_I;
			end
			ST_DT_RD_I: state_d = ST_DT_RD_J;
			ST_DT_RD_J: state_d = ST_DT_WR_I;
			ST_DT_WR_I: state_d = ST_DT_WR_J;
			ST_DT_WR_J: state_d = ST_DT_DONE;
			ST_DT_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: memory requests, adder operands, status
	always_comb begin
		s_req      = '0;
		add_a      = '0;
		add_b      = '0;
		add_c      = '0;
		k_we       = 1'b0;
		k_waddr    = key_count_q[KEY_AW-1:0];
		k_wdata    = item.value_in;
		k_raddr    = k_idx_q;
		item.ready = 1'b0;
		stat.idle  = 1'b0;
		stat.sched = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				stat.idle  = 1'b1;
				k_we       = item.valid && (item.kind == KIND_KEY) && key_room;
			end
			ST_KS_INIT: begin
				stat.sched  = 1'b1;
				s_req.we    = 1'b1;
				s_req.waddr = n_q;
				s_req.wdata = n_q;
			end
			ST_KS_RD_I: begin
				stat.sched  = 1'b1;
				s_req.raddr = n_q;
			end
			ST_KS_RD_J: begin
				stat.sched  = 1'b1;
				add_a       = j_q;
				add_b       = s_rdata;
				add_c       = k_rdata;
				s_req.raddr = sum;
			end
			ST_KS_WR_I: begin
				stat.sched  = 1'b1;
				s_req.we    = 1'b1;
				s_req.waddr = n_q;
				s_req.wdata = s_rdata;
			end
			ST_KS_WR_J: begin
				stat.sched  = 1'b1;
				s_req.we    = 1'b1;
				s_req.waddr = j_q;
				s_req.wdata = si_q;
			end
			ST_DT_RD_I: begin
				add_a       = i_q;
				add_b       = 8'd1;
				s_req.raddr = sum;
			end
			ST_DT_RD_J: begin
				add_a       = j_q;
				add_b       = s_rdata;
				s_req.raddr = sum;
			end
			ST_DT_WR_I: begin
				add_a       = si_q;
				add_b       = s_rdata;
				s_req.raddr = sum;
				s_req.we    = 1'b1;
				s_req.waddr = i_q;
				s_req.wdata = s_rdata;
			end
			ST_DT_WR_J: begin
				s_req.we    = 1'b1;
				s_req.waddr = j_q;
				s_req.wdata = si_q;
			end
			ST_DT_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			keyed_q     <= 1'b0;
			key_count_q <= '0;
			i_q         <= '0;
			j_q         <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (result.valid && result.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && item.kind == KIND_KEY) begin
						if (key_room) begin
							key_count_q <= key_count_q + KEY_CW'(1);
						end
						if (item.last_key) begin
							j_q <= '0;
						end
					end
				end
				ST_KS_RD_J: j_q <= sum;
				ST_KS_WR_J: begin
					if (n_q == 8'hFF) begin
						i_q         <= '0;
						j_q         <= '0;
						keyed_q     <= 1'b1;
						key_count_q <= '0;
					end
				end
				ST_DT_RD_I: i_q <= sum;
				ST_DT_RD_J: j_q <= sum;
				ST_DT_DONE: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					val_q   <= item.value_in;
					nk_q    <= !keyed_q;
					n_q     <= '0;
					k_idx_q <= '0;
				end
			end
			ST_KS_INIT: n_q <= n_q + 8'd1;
			ST_KS_RD_J: begin
				si_q    <= s_rdata;
				k_idx_q <= (k_inc == key_len) ? '0 : k_inc[KEY_AW-1:0];
			end
			ST_KS_WR_J: n_q <= n_q + 8'd1;
			ST_DT_RD_J: si_q <= s_rdata;
			ST_DT_WR_I: begin
				sj_q <= s_rdata;
				t_q  <= sum;
			end
			ST_DT_WR_J: ks_q <= ks_fwd;
			ST_DT_DONE: begin
				if (out_free) begin
					out_data_q <= nk_q ? 8'h00 : (val_q ^ ks_q);
					out_nk_q   <= nk_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid     = out_vld_q;
	assign result.data_out  = out_data_q;
	assign result.not_keyed = out_nk_q;

endmodule

>>> design/rc4_stream_cipher.sv
// RC4 byte cipher top level: sequencer, permutation memory and key memory.
// Key byte: the sequencer stays idle, so the next request is taken in the cycle after. The last
// key byte adds the key schedule: identity fill in KS_INIT, then KS_RD_I, KS_RD_J, KS_WR_I and
// KS_WR_J per entry on the one-read, one-write RAM. Data byte: DT_RD_I, DT_RD_J, DT_WR_I, DT_WR_J,
// then DT_DONE registers the result. Not-keyed data byte: DT_DONE only. A held result stalls.
// Reset clears the sequencer, indices, key count and keyed flag; the RAMs are not cleared.
`include "rc4_stream_cipher_assert.svh"
module rc4_stream_cipher #(
	parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rc4_in_if.sink    item,
	rc4_out_if.source result
);
	import rc4_pkg::*;

	localparam int KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

	s_req_t            s_req;
	logic [7:0]        s_rdata;
	logic              k_we;
	logic [KEY_AW-1:0] k_waddr, k_raddr;
	logic [7:0]        k_wdata, k_rdata;
	stat_t             stat;
	logic              last_key_acc;

	// Sequencer
	rc4_ctrl #(
		.KEY_MAX(KEY_MAX)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.result  (result),
		.s_req   (s_req),
		.s_rdata (s_rdata),
		.k_we    (k_we),
		.k_waddr (k_waddr),
		.k_wdata (k_wdata),
		.k_raddr (k_raddr),
		.k_rdata (k_rdata),
		.stat    (stat)
	);

	// Permutation memory
	rc4_ram #(
		.DEPTH(SBOX_DEPTH),
		.WIDTH(8)
	) u_sbox (
		.clk   (clk),
		.we    (s_req.we),
		.waddr (s_req.waddr),
		.wdata (s_req.wdata),
		.raddr (s_req.raddr),
		.rdata (s_rdata)
	);

	// Key memory
	rc4_ram #(
		.DEPTH(KEY_MAX),
		.WIDTH(8)
	) u_key (
		.clk   (clk),
		.we    (k_we),
		.waddr (k_waddr),
		.wdata (k_wdata),
		.raddr (k_raddr),
		.rdata (k_rdata)
	);

	// Checks
	assign last_key_acc = item.valid && item.ready && (item.kind == KIND_KEY) && item.last_key;

	`RC4_ASSERT_IMP(a_ready_only_idle, item.ready, stat.idle)
	`RC4_ASSERT_NXT(a_last_key_starts_sched, last_key_acc, stat.sched)
	`RC4_ASSERT_IMP(a_not_keyed_zero, result.valid && result.not_keyed, result.data_out == 8'h00)

endmodule
